// File: design/ccfr_pkg.sv
package ccfr_pkg;

	localparam int MAX_PAYLOAD = 256;
	localparam int RAW_LIMIT   = 264;
	localparam int HDR_LEN     = 4;

	localparam logic [7:0] DELIM_BYTE = 8'h00;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] FULL_CODE  = 8'hFF;

	localparam int RAW_W  = $clog2(RAW_LIMIT + 1);
	localparam int DC_W   = $clog2(MAX_PAYLOAD + HDR_LEN + 2);
	localparam int IDX_W  = $clog2(MAX_PAYLOAD);
	localparam int LEN_W  = 9;
	localparam int RAM_DEPTH = 2 * MAX_PAYLOAD;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_TRUNCATED = 3'd2,
		ERR_SIZE      = 3'd3,
		ERR_CRC       = 3'd4,
		ERR_LENGTH    = 3'd5
	} err_kind_t;

	typedef struct packed {
		logic       func;
		logic [7:0] line_byte;
		logic [7:0] read_index;
	} req_t;

	typedef struct packed {
		logic             frame_done;
		logic             frame_ok;
		err_kind_t        error_kind;
		logic [7:0]       command;
		logic [7:0]       direction;
		logic [LEN_W-1:0] data_length;
		logic [7:0]       read_data;
	} rsp_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		c = crc ^ d;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: design/ccfr_ram.sv
module ccfr_ram #(
	parameter int Width = 8,
	parameter int Depth = 512,
	localparam int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/cobs_crc8_frame_receiver_unit.sv
// channel | signals                    | transfer when
// --------+----------------------------+-------------------------
// req     | req_valid, req_ready, req  | req_valid & req_ready
// rsp     | rsp_valid, rsp_ready, rsp  | rsp_valid & rsp_ready
//
// One request per cycle while rsp is not stalled; each response passes through stage 1 and then the rsp register.
// Frame state and the payload RAM update in the transfer cycle; read data from the registered read port of the
// payload RAM joins the response in stage 1.
// arst_n clears frame state and selects bank 0; the payload RAM holds no reset.
// A stalled rsp holds the two stages; req_ready stays high while either stage can move.
module cobs_crc8_frame_receiver_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ccfr_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ccfr_pkg::rsp_t  rsp
);

	logic                       in_frame_q, in_frame_d;
	logic [ccfr_pkg::RAW_W-1:0] raw_q, raw_d;
	logic [7:0]                 held_q, held_d;
	logic [7:0]                 br_q, br_d;
	logic                       zp_q, zp_d;
	logic [ccfr_pkg::DC_W-1:0]  dc_q, dc_d;
	logic [7:0]                 crc_q, crc_d;
	logic [31:0]                hdr_q, hdr_d;
	logic                       good_q, good_d;

	logic                        req_fire, s1_move;
	logic                        valid_s1, rd_s1;
	ccfr_pkg::rsp_t              res_s1, res_d;
	logic                        rsp_valid_q;
	ccfr_pkg::rsp_t              rsp_q, rsp_d;

	logic                         ram_we, ram_re;
	logic [ccfr_pkg::RAM_AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]                   ram_wdata, ram_rdata;

	logic                         emit_en;
	logic [7:0]                   emit_d;
	logic [ccfr_pkg::DC_W-1:0]    dlen_dc;
	logic [15:0]                  dlen;
	ccfr_pkg::err_kind_t          err;

	assign s1_move   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || s1_move;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign dlen    = hdr_q[15:0];
	assign dlen_dc = dc_q - ccfr_pkg::DC_W'(ccfr_pkg::HDR_LEN);

	always_comb begin
		if (raw_q < ccfr_pkg::RAW_W'(2)) begin
			err = ccfr_pkg::ERR_SHORT;
		end else if (br_q != 8'd0) begin
			err = ccfr_pkg::ERR_TRUNCATED;
		end else if (dc_q < ccfr_pkg::DC_W'(ccfr_pkg::HDR_LEN) ||
				dc_q > ccfr_pkg::DC_W'(ccfr_pkg::MAX_PAYLOAD + ccfr_pkg::HDR_LEN)) begin
			err = ccfr_pkg::ERR_SIZE;
		end else if (crc_q != held_q) begin
			err = ccfr_pkg::ERR_CRC;
		end else if (dlen != 16'(dlen_dc)) begin
			err = ccfr_pkg::ERR_LENGTH;
		end else begin
			err = ccfr_pkg::ERR_NONE;
		end
	end

	always_comb begin
		in_frame_d = in_frame_q;
		raw_d      = raw_q;
		held_d     = held_q;
		br_d       = br_q;
		zp_d       = zp_q;
		dc_d       = dc_q;
		crc_d      = crc_q;
		hdr_d      = hdr_q;
		good_d     = good_q;
		res_d      = '0;
		ram_we     = 1'b0;
		ram_waddr  = {!good_q, dlen_dc[ccfr_pkg::IDX_W-1:0]};
		ram_re     = 1'b0;
		ram_raddr  = {good_q, req.read_index[ccfr_pkg::IDX_W-1:0]};
		emit_en    = 1'b0;
		emit_d     = held_q;

		if (req_fire) begin
			if (req.func) begin
				ram_re = 1'b1;
			end else if (!in_frame_q) begin
				if (req.line_byte != ccfr_pkg::DELIM_BYTE) begin
					in_frame_d = 1'b1;
					raw_d      = ccfr_pkg::RAW_W'(1);
					held_d     = req.line_byte;
				end
			end else if (raw_q >= ccfr_pkg::RAW_W'(ccfr_pkg::RAW_LIMIT) ||
					req.line_byte == ccfr_pkg::DELIM_BYTE) begin
				if (req.line_byte == ccfr_pkg::DELIM_BYTE &&
						raw_q < ccfr_pkg::RAW_W'(ccfr_pkg::RAW_LIMIT)) begin
					res_d.frame_done = 1'b1;
					res_d.error_kind = err;
					if (err == ccfr_pkg::ERR_NONE) begin
						res_d.frame_ok    = 1'b1;
						res_d.command     = hdr_q[31:24];
						res_d.direction   = hdr_q[23:16];
						res_d.data_length = dlen[ccfr_pkg::LEN_W-1:0];
						good_d            = !good_q;
					end
				end
				in_frame_d = 1'b0;
				raw_d      = '0;
				held_d     = '0;
				br_d       = '0;
				zp_d       = 1'b0;
				dc_d       = '0;
				crc_d      = '0;
				hdr_d      = '0;
			end else begin
				if (br_q == 8'd0) begin
					emit_en = zp_q;
					emit_d  = 8'h00;
					zp_d    = held_q != ccfr_pkg::FULL_CODE;
					br_d    = held_q - 8'd1;
				end else begin
					emit_en = 1'b1;
					br_d    = br_q - 8'd1;
				end
				if (emit_en) begin
					crc_d = ccfr_pkg::crc8_step(crc_q, emit_d);
					if (dc_q < ccfr_pkg::DC_W'(ccfr_pkg::HDR_LEN)) begin
						case (dc_q[1:0])
							2'd0:    hdr_d[31:24] = emit_d;
							2'd1:    hdr_d[23:16] = emit_d;
							2'd2:    hdr_d[15:8]  = emit_d;
							default: hdr_d[7:0]   = emit_d;
						endcase
					end else if (dc_q < ccfr_pkg::DC_W'(ccfr_pkg::MAX_PAYLOAD +
							ccfr_pkg::HDR_LEN)) begin
						ram_we = 1'b1;
					end
					if (dc_q < ccfr_pkg::DC_W'(ccfr_pkg::MAX_PAYLOAD + ccfr_pkg::HDR_LEN + 1)) begin
						dc_d = dc_q + ccfr_pkg::DC_W'(1);
					end
				end
				held_d = req.line_byte;
				raw_d  = raw_q + ccfr_pkg::RAW_W'(1);
			end
		end
		ram_wdata = emit_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			raw_q      <= '0;
			held_q     <= '0;
			br_q       <= '0;
			zp_q       <= 1'b0;
			dc_q       <= '0;
			crc_q      <= '0;
			hdr_q      <= '0;
			good_q     <= 1'b0;
		end else begin
			in_frame_q <= in_frame_d;
			raw_q      <= raw_d;
			held_q     <= held_d;
			br_q       <= br_d;
			zp_q       <= zp_d;
			dc_q       <= dc_d;
			crc_q      <= crc_d;
			hdr_q      <= hdr_d;
			good_q     <= good_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_fire;
			end
			if (s1_move) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_comb begin
		rsp_d           = res_s1;
		rsp_d.read_data = rd_s1 ? ram_rdata : 8'h00;
	end

	// hold payload with its valid; RAM output holds while no read is issued
	always_ff @(posedge clk) begin
		if (req_fire) begin
			res_s1 <= res_d;
			rd_s1  <= req.func;
		end
		if (s1_move && valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	ccfr_ram #(
		.Width(8),
		.Depth(ccfr_pkg::RAM_DEPTH)
	) u_payload_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// File: design/ccfr_checker.sv
module ccfr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input ccfr_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ccfr_pkg::rsp_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("req changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_ok_implies_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_ok |-> rsp.frame_done && rsp.error_kind == ccfr_pkg::ERR_NONE)
		else $error("good frame without done or with error");

	a_no_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.frame_done |->
			rsp.error_kind == ccfr_pkg::ERR_NONE && rsp.command == 8'h00 &&
			rsp.direction == 8'h00 && rsp.data_length == '0)
		else $error("frame fields set without frame end");

	a_fail_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_done && !rsp.frame_ok |->
			rsp.error_kind != ccfr_pkg::ERR_NONE && rsp.read_data == 8'h00 &&
			rsp.data_length == '0)
		else $error("failed frame without error kind");

endmodule

bind cobs_crc8_frame_receiver_unit ccfr_checker u_ccfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

// File: tb/tb_cobs_crc8_frame_receiver_unit.sv
`timescale 1ns / 1ps

module tb_cobs_crc8_frame_receiver_unit;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 200;

	typedef logic [7:0] octets_t[$];

	typedef enum {
		FK_GOOD,
		FK_FLIP,
		FK_BAD_CRC,
		FK_BAD_LEN,
		FK_TRUNC,
		FK_SHORT,
		FK_SMALL,
		FK_NOISE,
		FK_OVERFLOW
	} frame_kind_t;

	class deframer_model_t;
		bit         in_frame;
		int         raw_count;
		bit         held_valid;
		logic [7:0] held_byte;
		logic [7:0] block_left;
		bit         zero_pending;
		int         plain_count;
		logic [7:0] crc;
		logic [31:0] header;
		logic [7:0] banks[2][ccfr_pkg::MAX_PAYLOAD];
		bit         written[2][ccfr_pkg::MAX_PAYLOAD];
		bit         good_bank;
		ccfr_pkg::rsp_t pending_reports[$];
		int         errors;

		function new();
			clear_frame();
			good_bank = 1'b0;
			errors = 0;
			foreach (written[b, i]) written[b][i] = 1'b0;
		endfunction

		static function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] d);
			logic [7:0] r;
			logic fb;
			r = c;
			for (int i = 7; i >= 0; i--) begin
				fb = r[7] ^ d[i];
				r = {r[6:0], 1'b0};
				if (fb) r = r ^ ccfr_pkg::CRC_POLY;
			end
			return r;
		endfunction

		function void clear_frame();
			in_frame = 1'b0;
			raw_count = 0;
			held_valid = 1'b0;
			held_byte = 8'h00;
			block_left = 8'h00;
			zero_pending = 1'b0;
			plain_count = 0;
			crc = 8'h00;
			header = 32'h0;
		endfunction

		function void store_plain(logic [7:0] d);
			int idx;
			crc = crc8_next(crc, d);
			if (plain_count < ccfr_pkg::HDR_LEN) begin
				header[8 * (3 - plain_count) +: 8] = d;
			end else begin
				idx = plain_count - ccfr_pkg::HDR_LEN;
				if (idx < ccfr_pkg::MAX_PAYLOAD) begin
					banks[!good_bank][idx] = d;
					written[!good_bank][idx] = 1'b1;
				end
			end
			if (plain_count < ccfr_pkg::MAX_PAYLOAD + ccfr_pkg::HDR_LEN + 1) plain_count++;
		endfunction

		function void take_coded(logic [7:0] b);
			if (block_left == 8'h00) begin
				if (zero_pending) store_plain(8'h00);
				zero_pending = (b != ccfr_pkg::FULL_CODE);
				block_left = b - 8'd1;
			end else begin
				store_plain(b);
				block_left--;
			end
		endfunction

		function ccfr_pkg::rsp_t predict(ccfr_pkg::req_t r);
			ccfr_pkg::rsp_t o;
			ccfr_pkg::err_kind_t e;
			logic [15:0] dlen;
			o = '0;
			o.error_kind = ccfr_pkg::ERR_NONE;
			if (r.func) begin
				if (r.read_index < ccfr_pkg::MAX_PAYLOAD)
					o.read_data = banks[good_bank][r.read_index];
				return o;
			end
			if (!in_frame) begin
				if (r.line_byte != ccfr_pkg::DELIM_BYTE) begin
					in_frame = 1'b1;
					raw_count = 1;
					held_byte = r.line_byte;
					held_valid = 1'b1;
				end
				return o;
			end
			if (raw_count >= ccfr_pkg::RAW_LIMIT) begin
				clear_frame();
				return o;
			end
			if (r.line_byte == ccfr_pkg::DELIM_BYTE) begin
				dlen = header[15:0];
				e = ccfr_pkg::ERR_NONE;
				if (raw_count < 2)
					e = ccfr_pkg::ERR_SHORT;
				else if (block_left != 8'h00)
					e = ccfr_pkg::ERR_TRUNCATED;
				else if (plain_count < ccfr_pkg::HDR_LEN ||
						plain_count > ccfr_pkg::MAX_PAYLOAD + ccfr_pkg::HDR_LEN)
					e = ccfr_pkg::ERR_SIZE;
				else if (crc != held_byte)
					e = ccfr_pkg::ERR_CRC;
				else if (dlen != plain_count - ccfr_pkg::HDR_LEN)
					e = ccfr_pkg::ERR_LENGTH;
				o.frame_done = 1'b1;
				if (e == ccfr_pkg::ERR_NONE) begin
					good_bank = !good_bank;
					o.frame_ok = 1'b1;
					o.command = header[31:24];
					o.direction = header[23:16];
					o.data_length = dlen[ccfr_pkg::LEN_W-1:0];
				end else begin
					o.error_kind = e;
				end
				clear_frame();
				return o;
			end
			if (held_valid) take_coded(held_byte);
			held_byte = r.line_byte;
			held_valid = 1'b1;
			raw_count++;
			return o;
		endfunction

		function void note_request(ccfr_pkg::req_t r);
			pending_reports.insert(pending_reports.size(), predict(r));
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_report(ccfr_pkg::rsp_t got);
			ccfr_pkg::rsp_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected response, expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("frame_done", want.frame_done, got.frame_done);
			compare_field("frame_ok", want.frame_ok, got.frame_ok);
			compare_field("error_kind", want.error_kind, got.error_kind);
			compare_field("command", want.command, got.command);
			compare_field("direction", want.direction, got.direction);
			compare_field("data_length", want.data_length, got.data_length);
			compare_field("read_data", want.read_data, got.read_data);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	ccfr_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	ccfr_pkg::rsp_t rsp;

	deframer_model_t deframer;
	int unsigned cycle_count;
	int item_count;
	int gap_odds;
	bit calm;

	cobs_crc8_frame_receiver_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) deframer.check_report(rsp);
	end

	initial begin
		int stall;
		int mode_left;
		bit busy;
		stall = 0;
		mode_left = 0;
		busy = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				busy = ($urandom_range(0, 2) != 0);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			if (stall > 0) begin
				stall--;
				rsp_ready <= 1'b0;
			end else if (!calm && busy && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 7) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input ccfr_pkg::req_t item, input bit counted);
		if (!calm && gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		deframer.note_request(item);
		if (counted) item_count++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit counted);
		ccfr_pkg::req_t r;
		r.func = 1'b0;
		r.line_byte = b;
		r.read_index = 8'($urandom);
		send_item(r, counted);
	endtask

	task automatic send_read_at(input logic [7:0] idx);
		ccfr_pkg::req_t r;
		r.func = 1'b1;
		r.line_byte = 8'($urandom);
		r.read_index = idx;
		send_item(r, 1'b1);
	endtask

	// read only entries of the current bank that some frame has written
	task automatic send_read();
		int pool[$];
		for (int i = 0; i < ccfr_pkg::MAX_PAYLOAD; i++) begin
			if (deframer.written[deframer.good_bank][i]) pool.insert(pool.size(), i);
		end
		if (pool.size() == 0) return;
		if ($urandom_range(0, 3) == 0)
			send_read_at(8'(pool[pool.size() - 1]));
		else
			send_read_at(8'(pool[$urandom_range(0, pool.size() - 1)]));
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (deframer.pending_reports.size() != 0);
	endtask

	function automatic logic [7:0] random_octet(int zero_odds);
		if (zero_odds > 0 && $urandom_range(0, zero_odds - 1) == 0) return 8'h00;
		if ($urandom_range(0, 7) == 0) return 8'hFF;
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] crc_of(octets_t q);
		logic [7:0] c;
		c = 8'h00;
		foreach (q[i]) c = deframer_model_t::crc8_next(c, q[i]);
		return c;
	endfunction

	function automatic void flush_block(ref octets_t coded, ref octets_t run,
			input logic [7:0] code);
		coded.insert(coded.size(), code);
		foreach (run[k]) coded.insert(coded.size(), run[k]);
		run.delete();
	endfunction

	function automatic octets_t stuff_frame(octets_t plain);
		octets_t coded;
		octets_t run;
		foreach (plain[i]) begin
			if (plain[i] == 8'h00) begin
				flush_block(coded, run, 8'(run.size() + 1));
			end else begin
				run.insert(run.size(), plain[i]);
				if (run.size() == 254) flush_block(coded, run, ccfr_pkg::FULL_CODE);
			end
		end
		flush_block(coded, run, 8'(run.size() + 1));
		return coded;
	endfunction

	task automatic send_frame(input frame_kind_t kind, input int n, input int zero_odds);
		octets_t body;
		octets_t line_q;
		logic [15:0] declared;
		logic [7:0] crc;
		logic [7:0] twist;
		logic [7:0] code;
		int idx;
		case (kind)
			FK_SHORT: line_q.insert(line_q.size(), 8'($urandom_range(1, 255)));
			FK_NOISE: repeat (n) line_q.insert(line_q.size(), random_octet(4));
			FK_OVERFLOW: repeat (ccfr_pkg::RAW_LIMIT + 2)
				line_q.insert(line_q.size(), 8'($urandom_range(1, 255)));
			default: begin
				if (kind == FK_SMALL) begin
					repeat (n) body.insert(body.size(), random_octet(zero_odds));
				end else begin
					declared = 16'(n);
					if (kind == FK_BAD_LEN) begin
						if ($urandom_range(0, 3) == 0)
							declared = 16'hFFFF;
						else
							declared = 16'(n + $urandom_range(1, 300));
					end
					body.insert(body.size(), 8'($urandom));
					body.insert(body.size(), 8'($urandom));
					body.insert(body.size(), declared[15:8]);
					body.insert(body.size(), declared[7:0]);
					repeat (n) body.insert(body.size(), random_octet(zero_odds));
					if (n > 200 && zero_odds > 0) body[ccfr_pkg::HDR_LEN + n / 2] = 8'h00;
				end
				crc = crc_of(body);
				while (crc == 8'h00) begin
					body[0] = body[0] + 8'd1;
					crc = crc_of(body);
				end
				line_q = stuff_frame(body);
				case (kind)
					FK_BAD_CRC: begin
						do twist = 8'($urandom_range(1, 255)); while ((crc ^ twist) == 8'h00);
						crc = crc ^ twist;
					end
					FK_TRUNC: begin
						code = 8'($urandom_range(2, 255));
						line_q.insert(line_q.size(), code);
						repeat ($urandom_range(0, (code > 7) ? 5 : code - 2))
							line_q.insert(line_q.size(), 8'($urandom_range(1, 255)));
					end
					FK_FLIP: begin
						idx = $urandom_range(0, line_q.size() - 1);
						line_q[idx] = 8'($urandom_range(1, 255));
					end
					default: ;
				endcase
				line_q.insert(line_q.size(), crc);
			end
		endcase
		line_q.insert(line_q.size(), ccfr_pkg::DELIM_BYTE);
		foreach (line_q[i]) begin
			if ($urandom_range(0, 14) == 0) send_read();
			send_byte(line_q[i], 1'b1);
		end
	endtask

	initial begin
		int directed_end;
		int pick;
		int n;
		deframer = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		gap_odds = 8;
		item_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		repeat (2) send_byte(ccfr_pkg::DELIM_BYTE, 1'b0);
		send_frame(FK_GOOD, 0, 0);
		send_frame(FK_GOOD, 3, 2);
		repeat (3) send_read();
		send_frame(FK_SHORT, 0, 0);
		send_frame(FK_TRUNC, 2, 0);
		send_frame(FK_SMALL, 2, 0);
		send_frame(FK_BAD_CRC, 4, 3);
		send_frame(FK_BAD_LEN, 4, 3);
		send_frame(FK_GOOD, ccfr_pkg::MAX_PAYLOAD, 0);
		send_read_at(8'd255);
		send_read_at(8'd0);
		send_frame(FK_GOOD, ccfr_pkg::MAX_PAYLOAD + 1, 16);
		send_frame(FK_OVERFLOW, 0, 0);
		send_read_at(8'd255);
		drain_results();

		directed_end = item_count;
		while (item_count < directed_end + RANDOM_ITEMS) begin
			calm = (item_count > directed_end + RANDOM_ITEMS - 150);
			gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
			pick = $urandom_range(0, 99);
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 24);
			if (pick < 45) begin
				if ($urandom_range(0, 24) == 0) n = $urandom_range(100, ccfr_pkg::MAX_PAYLOAD);
				send_frame(FK_GOOD, n, $urandom_range(0, 8));
			end else if (pick < 55) begin
				send_frame(FK_FLIP, n, $urandom_range(0, 8));
			end else if (pick < 62) begin
				send_frame(FK_BAD_CRC, n, $urandom_range(0, 8));
			end else if (pick < 68) begin
				send_frame(FK_BAD_LEN, n, $urandom_range(0, 8));
			end else if (pick < 73) begin
				send_frame(FK_TRUNC, n, $urandom_range(0, 8));
			end else if (pick < 77) begin
				send_frame(FK_SHORT, 0, 0);
			end else if (pick < 81) begin
				send_frame(FK_SMALL, $urandom_range(1, 3), $urandom_range(0, 4));
			end else if (pick < 88) begin
				send_frame(FK_NOISE, $urandom_range(1, 12), 0);
			end else if (pick < 89) begin
				send_frame(FK_OVERFLOW, 0, 0);
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 3)) send_byte(ccfr_pkg::DELIM_BYTE, 1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) send_read();
			end
			if ($urandom_range(0, 29) == 0) drain_results();
		end

		calm = 1'b1;
		drain_results();
		repeat (8) @(posedge clk);
		if (deframer.errors == 0 && deframer.pending_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
